### hdl/iee_pkg.sv
// ----------------------------------------------------------------------------
// iee_pkg
// Types, character codes and helpers shared by the infix expression evaluator.
// ----------------------------------------------------------------------------
package iee_pkg;

	localparam int DATA_W = 32;
	localparam int CHAR_W = 8;

	localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_MUL   = 8'h2A;
	localparam logic [CHAR_W-1:0] CHAR_DIV   = 8'h2F;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
	localparam logic [DATA_W-1:0] DEC_BASE   = 32'd10;

	typedef enum logic [2:0] {
		OP_PLUS  = 3'd0,
		OP_MINUS = 3'd1,
		OP_MUL   = 3'd2,
		OP_DIV   = 3'd3,
		OP_OTHER = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_APPLY,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		logic              last_char;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     div_zero;
	} out_item_t;

	typedef struct packed {
		logic accept;
		logic add_term;
		logic mul_term;
		logic div_zero;
		logic div_start;
		logic div_write;
		logic close;
		logic emit;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic in_close;
		logic last;
		logic num_zero;
		logic div_done;
	} status_t;

	function automatic logic is_digit(input logic [CHAR_W-1:0] c);
		return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
	endfunction

	function automatic logic is_space(input logic [CHAR_W-1:0] c);
		return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
	endfunction

	function automatic op_t op_code(input logic [CHAR_W-1:0] c);
		op_t op;
		case (c)
			CHAR_PLUS:  op = OP_PLUS;
			CHAR_MINUS: op = OP_MINUS;
			CHAR_MUL:   op = OP_MUL;
			CHAR_DIV:   op = OP_DIV;
			default:    op = OP_OTHER;
		endcase
		return op;
	endfunction

endpackage

### hdl/infix_expression_evaluator.sv
// ----------------------------------------------------------------------------
// infix_expression_evaluator: digits and spaces are taken in ST_IDLE; + - * or other
// characters apply the pending operator in ST_APPLY; a division by a nonzero number
// waits in ST_DIV for the one-bit-per-cycle divider, a division by zero sets the error
// flag, and the last character loads the output register in ST_FIN. Async reset clears
// sum, term, number, error, sets the pending operator to plus and drops out_valid.
// ----------------------------------------------------------------------------
module infix_expression_evaluator (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  iee_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output iee_pkg::out_item_t  out_data
);

	iee_pkg::cmd_t    cmd;
	iee_pkg::status_t status;

	iee_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	iee_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.status   (status),
		.out_data (out_data)
	);

endmodule

### hdl/iee_div.sv
// ----------------------------------------------------------------------------
// iee_div
// Signed restoring divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module iee_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [iee_pkg::DATA_W-1:0]     dividend,
	input  logic [iee_pkg::DATA_W-1:0]     divisor,
	output logic                           done,
	output logic [iee_pkg::DATA_W-1:0]     quotient
);

	localparam int W     = iee_pkg::DATA_W;
	localparam int CNT_W = $clog2(W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     quo_q;
	logic [W-1:0]     dvs_q;
	logic             neg_q;

	logic [W-1:0]     a_abs;
	logic [W-1:0]     b_abs;
	logic [W:0]       shifted;
	logic [W+1:0]     diff;
	logic             ge;

	assign a_abs   = dividend[W-1] ? (~dividend + 1'b1) : dividend;
	assign b_abs   = divisor[W-1]  ? (~divisor + 1'b1)  : divisor;
	assign shifted = {rem_q, quo_q[W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
	assign ge      = ~diff[W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= a_abs;
			dvs_q <= b_abs;
			neg_q <= dividend[W-1] ^ divisor[W-1];
		end else if (busy_q) begin
			rem_q <= ge ? diff[W-1:0] : shifted[W-1:0];
			quo_q <= {quo_q[W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

### hdl/iee_dpath.sv
// ----------------------------------------------------------------------------
// iee_dpath
// Sum, term and number registers with the add, multiply and divide units.
// ----------------------------------------------------------------------------
module iee_dpath (
	input  logic                clk,
	input  logic                arst_n,
	input  iee_pkg::in_item_t   in_data,
	input  iee_pkg::cmd_t       cmd,
	output iee_pkg::status_t    status,
	output iee_pkg::out_item_t  out_data
);

	localparam int W = iee_pkg::DATA_W;

	logic [iee_pkg::CHAR_W-1:0] char_q;
	logic                       last_q;
	logic [W-1:0]               sum_q;
	logic [W-1:0]               term_q;
	logic [W-1:0]               num_q;
	iee_pkg::op_t               op_q;
	logic                       err_q;
	iee_pkg::out_item_t         out_q;

	logic [W-1:0]               num_next;
	logic [W-1:0]               product;
	logic [W-1:0]               quotient;
	logic                       div_done;

	iee_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (term_q),
		.divisor  (num_q),
		.done     (div_done),
		.quotient (quotient)
	);

	assign num_next = num_q * iee_pkg::DEC_BASE
		+ W'(in_data.char_code - iee_pkg::CHAR_ZERO);
	assign product  = term_q * num_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			char_q <= in_data.char_code;
			last_q <= in_data.last_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			term_q <= '0;
			num_q  <= '0;
			op_q   <= iee_pkg::OP_PLUS;
			err_q  <= 1'b0;
		end else begin
			// emit returns sum, term, number, operator and error to their reset values
			if (cmd.emit) begin
				sum_q  <= '0;
				term_q <= '0;
				num_q  <= '0;
				op_q   <= iee_pkg::OP_PLUS;
				err_q  <= 1'b0;
			end else begin
				if (cmd.accept && iee_pkg::is_digit(in_data.char_code)) begin
					num_q <= num_next;
				end
				if (cmd.add_term) begin
					sum_q  <= sum_q + term_q;
					term_q <= (op_q == iee_pkg::OP_MINUS) ? (~num_q + 1'b1) : num_q;
				end
				if (cmd.mul_term) begin
					term_q <= product;
				end
				if (cmd.div_zero) begin
					term_q <= '0;
					err_q  <= 1'b1;
				end
				if (cmd.div_write) begin
					term_q <= quotient;
				end
				if (cmd.close) begin
					op_q  <= iee_pkg::op_code(char_q);
					num_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.value    <= signed'(sum_q + term_q);
			out_q.div_zero <= err_q;
		end
	end

	assign status.op       = op_q;
	assign status.in_close = in_data.last_char
		|| (!iee_pkg::is_digit(in_data.char_code) && !iee_pkg::is_space(in_data.char_code));
	assign status.last     = last_q;
	assign status.num_zero = (num_q == '0);
	assign status.div_done = div_done;
	assign out_data        = out_q;

endmodule

### hdl/iee_ctrl.sv
// ----------------------------------------------------------------------------
// iee_ctrl
// Sequencer: takes a request, applies the pending operator, emits the result.
// ----------------------------------------------------------------------------
module iee_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  iee_pkg::status_t  status,
	output iee_pkg::cmd_t     cmd
);

	iee_pkg::state_t state_q;
	iee_pkg::state_t state_next;
	logic            out_valid_q;
	logic            close_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= iee_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		cmd        = '0;
		state_next = state_q;
		close_next = 1'b0;
		in_ready   = 1'b0;
		case (state_q)
			iee_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (status.in_close) begin
						state_next = iee_pkg::ST_APPLY;
					end
				end
			end
			iee_pkg::ST_APPLY: begin
				close_next = 1'b1;
				case (status.op)
					iee_pkg::OP_PLUS, iee_pkg::OP_MINUS: cmd.add_term = 1'b1;
					iee_pkg::OP_MUL: cmd.mul_term = 1'b1;
					iee_pkg::OP_DIV: begin
						if (status.num_zero) begin
							cmd.div_zero = 1'b1;
						end else begin
							cmd.div_start = 1'b1;
							close_next    = 1'b0;
							state_next    = iee_pkg::ST_DIV;
						end
					end
					default: ;
				endcase
			end
			iee_pkg::ST_DIV: begin
				if (status.div_done) begin
					cmd.div_write = 1'b1;
					close_next    = 1'b1;
				end
			end
			iee_pkg::ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.emit   = 1'b1;
					state_next = iee_pkg::ST_IDLE;
				end
			end
			default: state_next = iee_pkg::ST_IDLE;
		endcase
		if (close_next) begin
			cmd.close  = 1'b1;
			state_next = status.last ? iee_pkg::ST_FIN : iee_pkg::ST_IDLE;
		end
	end

	assign out_valid = out_valid_q;

endmodule
